### hw/rtl/depth_pixel_reprojection_defines.svh
// ---------------------------------------------------------------------------
// Depth pixel reprojection: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_REPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_REPROJECTION_DEFINES_SVH

// Same-cycle implication.
`define DPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpr: same-cycle check failed");

// Next-cycle implication.
`define DPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpr: next-cycle check failed");

`endif

### hw/rtl/dpr_pkg.sv
// ---------------------------------------------------------------------------
// dpr_pkg
// Widths, register indexes and divider types for the depth reprojection.
// ---------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COL_W      = 12;
  localparam int DEPTH_W    = 32;
  localparam int POS_W      = 32;
  localparam logic [COL_W-1:0] COORD_MASK = COL_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_INTR  = 3'd0,
    REG_TGT_INTR  = 3'd1,
    REG_ROT_FIRST = 3'd2,
    REG_ROT_SECND = 3'd3,
    REG_ROT_LAST  = 3'd4,
    REG_TRANS_XY  = 3'd5,
    REG_TRANS_Z   = 3'd6
  } cfg_reg_t;

  // Divider: dividend magnitude, divisor, quotient bits, remainder, stage count.
  localparam int NUM_W      = 60;
  localparam int DEN_W      = 31;
  localparam int QB         = 34;
  localparam int REM_W      = 32;
  localparam int DIV_STAGES = QB + 1;

  typedef struct packed {
    logic        bad;
    logic [31:0] word;
  } div_side_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    w;
  } div_lane_t;

endpackage

`default_nettype wire

### hw/rtl/dpr_in_if.sv
// ---------------------------------------------------------------------------
// dpr_in_if
// Input channel: one depth pixel per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface dpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [dpr_pkg::COL_W-1:0]   column;
  logic [dpr_pkg::COL_W-1:0]   row;
  logic [dpr_pkg::DEPTH_W-1:0] depth;

  modport source (output valid, column, row, depth, input ready);
  modport sink   (input valid, column, row, depth, output ready);
endinterface

`default_nettype wire

### hw/rtl/dpr_out_if.sv
// ---------------------------------------------------------------------------
// dpr_out_if
// Result channel: projected target position and its valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface dpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dpr_pkg::POS_W-1:0] target_x;
  logic signed [dpr_pkg::POS_W-1:0] target_y;
  logic                             valid_res;

  modport source (output valid, target_x, target_y, valid_res, input ready);
  modport sink   (input valid, target_x, target_y, valid_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/dpr_div.sv
// ---------------------------------------------------------------------------
// dpr_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module dpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  dpr_pkg::div_side_t        in_side,
  input  logic                      in_neg_x,
  input  logic [dpr_pkg::NUM_W-1:0] in_mag_x,
  input  logic [dpr_pkg::DEN_W-1:0] in_den_x,
  input  logic                      in_neg_y,
  input  logic [dpr_pkg::NUM_W-1:0] in_mag_y,
  input  logic [dpr_pkg::DEN_W-1:0] in_den_y,
  output logic                      out_vld,
  output dpr_pkg::div_side_t        out_side,
  output logic                      out_neg_x,
  output logic                      out_ovf_x,
  output logic [dpr_pkg::QB-1:0]    out_q_x,
  output logic                      out_neg_y,
  output logic                      out_ovf_y,
  output logic [dpr_pkg::QB-1:0]    out_q_y
);
  import dpr_pkg::*;

  // Flag overflow when the quotient needs more than QB bits.
  function automatic div_lane_t div_init(logic neg, logic [NUM_W-1:0] mag,
                                         logic [DEN_W-1:0] den);
    div_lane_t l;
    l.neg = neg;
    l.den = den;
    l.rem = REM_W'(mag[NUM_W-1:QB]);
    l.ovf = (l.rem >= REM_W'(den));
    l.w   = mag[QB-1:0];
    return l;
  endfunction

  // Shift one dividend bit in, subtract when it fits, shift the quotient bit in.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t        o;
    logic [REM_W-1:0] t;
    logic             ge;
    o     = l;
    t     = {l.rem[REM_W-2:0], l.w[QB-1]};
    ge    = (t >= REM_W'(l.den));
    o.rem = ge ? (t - REM_W'(l.den)) : t;
    o.w   = {l.w[QB-2:0], ge};
    return o;
  endfunction

  logic [DIV_STAGES-1:0] vld_r;
  div_side_t             side_r [DIV_STAGES];
  div_lane_t             lx_r   [DIV_STAGES];
  div_lane_t             ly_r   [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      lx_r[0]   <= div_init(in_neg_x, in_mag_x, in_den_x);
      ly_r[0]   <= div_init(in_neg_y, in_mag_y, in_den_y);
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
        lx_r[k]   <= div_step(lx_r[k-1]);
        ly_r[k]   <= div_step(ly_r[k-1]);
      end
    end
  end

  assign out_vld   = vld_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];
  assign out_neg_x = lx_r[DIV_STAGES-1].neg;
  assign out_ovf_x = lx_r[DIV_STAGES-1].ovf;
  assign out_q_x   = lx_r[DIV_STAGES-1].w;
  assign out_neg_y = ly_r[DIV_STAGES-1].neg;
  assign out_ovf_y = ly_r[DIV_STAGES-1].ovf;
  assign out_q_y   = ly_r[DIV_STAGES-1].w;

endmodule

`default_nettype wire

### hw/rtl/depth_pixel_reprojection.sv
// ---------------------------------------------------------------------------
// depth_pixel_reprojection
// Pinhole back-projection, rigid transform and reprojection of depth pixels.
// ---------------------------------------------------------------------------
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+--------------------------------------
//  in_ch     | in  | valid/ready  | column[11:0], row[11:0], depth[31:0]
//  out_ch    | out | valid/ready  | target_x[31:0], target_y[31:0], valid_res
//  cfg_*     | in  | cfg_we       | cfg_index[2:0], cfg_data[63:0]
//
// One item enters per clock while out_ch is not stalled; the pipeline is the two
// 35-stage dividers (one quotient bit per stage) plus seven arithmetic stages.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// identity intrinsics and transform.
// A stall on out_ch freezes the whole pipeline; in_ch.ready drops together
// with it, so nothing is lost or repeated.
//
`default_nettype none

module depth_pixel_reprojection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpr_pkg::CFG_W-1:0]     cfg_data,
  dpr_in_if.sink                        in_ch,
  dpr_out_if.source                     out_ch
);
  import dpr_pkg::*;

  `include "depth_pixel_reprojection_defines.svh"

  localparam logic [QB-1:0] Q_POS_MAX = QB'(64'h7FFF_FFFF);
  localparam logic [QB-1:0] Q_NEG_MAX = QB'(64'h8000_0000);

  // Truncate a Q.30 product toward zero to Q.16.
  function automatic logic signed [34:0] trunc14(logic signed [48:0] p);
    logic signed [48:0] b;
    b = p + (p[48] ? 49'sd16383 : 49'sd0);
    return b[48:14];
  endfunction

  // ---- configuration registers -------------------------------------------
  logic [63:0]        src_intr_r, tgt_intr_r, rot_first_r, rot_secnd_r, trans_xy_r;
  logic signed [15:0] rot_last_r;
  logic signed [31:0] trans_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_intr_r  <= 64'h0000_0000_0010_0010;
      tgt_intr_r  <= 64'h0000_0000_0010_0010;
      rot_first_r <= 64'd16384;
      rot_secnd_r <= 64'd16384;
      rot_last_r  <= 16'sd16384;
      trans_xy_r  <= '0;
      trans_z_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_INTR:  src_intr_r  <= cfg_data;
        REG_TGT_INTR:  tgt_intr_r  <= cfg_data;
        REG_ROT_FIRST: rot_first_r <= cfg_data;
        REG_ROT_SECND: rot_secnd_r <= cfg_data;
        REG_ROT_LAST:  rot_last_r  <= cfg_data[15:0];
        REG_TRANS_XY:  trans_xy_r  <= cfg_data;
        REG_TRANS_Z:   trans_z_r   <= cfg_data[31:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  logic [15:0] sfx, sfy, scx, scy, tfx, tfy, tcx, tcy;
  assign sfx = src_intr_r[15:0];
  assign sfy = src_intr_r[31:16];
  assign scx = src_intr_r[47:32];
  assign scy = src_intr_r[63:48];
  assign tfx = tgt_intr_r[15:0];
  assign tfy = tgt_intr_r[31:16];
  assign tcx = tgt_intr_r[47:32];
  assign tcy = tgt_intr_r[63:48];

  logic signed [15:0] rot [9];
  assign rot[0] = rot_first_r[15:0];
  assign rot[1] = rot_first_r[31:16];
  assign rot[2] = rot_first_r[47:32];
  assign rot[3] = rot_first_r[63:48];
  assign rot[4] = rot_secnd_r[15:0];
  assign rot[5] = rot_secnd_r[31:16];
  assign rot[6] = rot_secnd_r[47:32];
  assign rot[7] = rot_secnd_r[63:48];
  assign rot[8] = rot_last_r;

  logic signed [31:0] tx, ty;
  assign tx = trans_xy_r[31:0];
  assign ty = trans_xy_r[63:32];

  // ---- pipeline advance: hold everything while the result waits -----------
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- stage A: depth times offset from the principal point --------------
  logic [15:0]        col16, row16;
  logic signed [16:0] diff_x, diff_y;
  logic [15:0]        dmag_x, dmag_y;
  logic               a_vld_r, a_bad_r, a_neg_x_r, a_neg_y_r;
  logic [31:0]        a_z_r;
  logic [47:0]        a_mag_x_r, a_mag_y_r;

  assign col16  = {in_ch.column & COORD_MASK, 4'b0000};
  assign row16  = {in_ch.row & COORD_MASK, 4'b0000};
  assign diff_x = $signed({1'b0, col16}) - $signed({1'b0, scx});
  assign diff_y = $signed({1'b0, row16}) - $signed({1'b0, scy});
  assign dmag_x = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
  assign dmag_y = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bad_r   <= (in_ch.depth == '0) || (sfx == '0) || (sfy == '0);
      a_z_r     <= in_ch.depth;
      a_neg_x_r <= diff_x[16];
      a_neg_y_r <= diff_y[16];
      a_mag_x_r <= in_ch.depth * dmag_x;
      a_mag_y_r <= in_ch.depth * dmag_y;
    end
  end

  // ---- back-projection divide by source focal lengths ---------------------
  logic          d1_vld, d1_neg_x, d1_ovf_x, d1_neg_y, d1_ovf_y;
  div_side_t     d1_side;
  logic [QB-1:0] d1_q_x, d1_q_y;

  dpr_div u_div_src (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (a_vld_r),
    .in_side   ('{bad: a_bad_r, word: a_z_r}),
    .in_neg_x  (a_neg_x_r),
    .in_mag_x  (NUM_W'(a_mag_x_r)),
    .in_den_x  (DEN_W'(sfx)),
    .in_neg_y  (a_neg_y_r),
    .in_mag_y  (NUM_W'(a_mag_y_r)),
    .in_den_y  (DEN_W'(sfy)),
    .out_vld   (d1_vld),
    .out_side  (d1_side),
    .out_neg_x (d1_neg_x),
    .out_ovf_x (d1_ovf_x),
    .out_q_x   (d1_q_x),
    .out_neg_y (d1_neg_y),
    .out_ovf_y (d1_ovf_y),
    .out_q_y   (d1_q_y)
  );

  // ---- stage B: sign and range of the camera-space point -----------------
  logic               ok_x1, ok_y1;
  logic               b_vld_r, b_bad_r;
  logic signed [31:0] b_x_r, b_y_r;
  logic [31:0]        b_z_r;

  assign ok_x1 = !d1_ovf_x && (d1_neg_x ? (d1_q_x <= Q_NEG_MAX) : (d1_q_x <= Q_POS_MAX));
  assign ok_y1 = !d1_ovf_y && (d1_neg_y ? (d1_q_y <= Q_NEG_MAX) : (d1_q_y <= Q_POS_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_bad_r <= d1_side.bad || !ok_x1 || !ok_y1;
      b_x_r   <= d1_neg_x ? -d1_q_x[31:0] : d1_q_x[31:0];
      b_y_r   <= d1_neg_y ? -d1_q_y[31:0] : d1_q_y[31:0];
      b_z_r   <= d1_side.word;
    end
  end

  // ---- stage C: nine rotation products -----------------------------------
  logic signed [32:0] pnt [3];
  logic               c_vld_r, c_bad_r;
  logic signed [48:0] c_p_r [9];
  logic signed [31:0] c_tz_unused_guard;

  assign pnt[0] = {b_x_r[31], b_x_r};
  assign pnt[1] = {b_y_r[31], b_y_r};
  assign pnt[2] = {1'b0, b_z_r};
  assign c_tz_unused_guard = trans_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_bad_r <= b_bad_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c_p_r[3*i+j] <= rot[3*i+j] * pnt[j];
        end
      end
    end
  end

  // ---- stage D: truncate products toward zero ----------------------------
  logic               d_vld_r, d_bad_r;
  logic signed [34:0] d_t_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_bad_r <= c_bad_r;
      for (int k = 0; k < 9; k++) begin
        d_t_r[k] <= trunc14(c_p_r[k]);
      end
    end
  end

  // ---- stage E: sum rows, add translation, range and sign checks ---------
  logic signed [36:0] xt, yt, zt;
  logic               fit_xt, fit_yt, fit_zt, zt_pos;
  logic               e_vld_r, e_bad_r;
  logic signed [31:0] e_xt_r, e_yt_r;
  logic [DEN_W-1:0]   e_zt_r;

  assign xt = 37'(d_t_r[0]) + 37'(d_t_r[1]) + 37'(d_t_r[2]) + 37'(tx);
  assign yt = 37'(d_t_r[3]) + 37'(d_t_r[4]) + 37'(d_t_r[5]) + 37'(ty);
  assign zt = 37'(d_t_r[6]) + 37'(d_t_r[7]) + 37'(d_t_r[8]) + 37'(c_tz_unused_guard);
  assign fit_xt = (xt[36:31] == '0) || (xt[36:31] == '1);
  assign fit_yt = (yt[36:31] == '0) || (yt[36:31] == '1);
  assign fit_zt = (zt[36:31] == '0) || (zt[36:31] == '1);
  assign zt_pos = !zt[36] && (zt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_bad_r <= d_bad_r || !fit_xt || !fit_yt || !fit_zt || !zt_pos;
      e_xt_r  <= xt[31:0];
      e_yt_r  <= yt[31:0];
      e_zt_r  <= zt[DEN_W-1:0];
    end
  end

  // ---- stage F: scale by target focal lengths ----------------------------
  logic [31:0]      mag_xt, mag_yt;
  logic             f_vld_r, f_bad_r, f_neg_x_r, f_neg_y_r;
  logic [47:0]      f_mag_x_r, f_mag_y_r;
  logic [DEN_W-1:0] f_zt_r;

  assign mag_xt = e_xt_r[31] ? 32'(-e_xt_r) : e_xt_r;
  assign mag_yt = e_yt_r[31] ? 32'(-e_yt_r) : e_yt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_bad_r   <= e_bad_r;
      f_neg_x_r <= e_xt_r[31];
      f_neg_y_r <= e_yt_r[31];
      f_mag_x_r <= mag_xt * tfx;
      f_mag_y_r <= mag_yt * tfy;
      f_zt_r    <= e_zt_r;
    end
  end

  // ---- projection divide by transformed depth ----------------------------
  logic          d2_vld, d2_neg_x, d2_ovf_x, d2_neg_y, d2_ovf_y;
  div_side_t     d2_side;
  logic [QB-1:0] d2_q_x, d2_q_y;

  dpr_div u_div_tgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (f_vld_r),
    .in_side   ('{bad: f_bad_r, word: 32'(f_zt_r)}),
    .in_neg_x  (f_neg_x_r),
    .in_mag_x  ({f_mag_x_r, 12'h000}),
    .in_den_x  (f_zt_r),
    .in_neg_y  (f_neg_y_r),
    .in_mag_y  ({f_mag_y_r, 12'h000}),
    .in_den_y  (f_zt_r),
    .out_vld   (d2_vld),
    .out_side  (d2_side),
    .out_neg_x (d2_neg_x),
    .out_ovf_x (d2_ovf_x),
    .out_q_x   (d2_q_x),
    .out_neg_y (d2_neg_y),
    .out_ovf_y (d2_ovf_y),
    .out_q_y   (d2_q_y)
  );

  // ---- stage G: add principal point, final range check, output register --
  logic signed [35:0] qs_x, qs_y, u_x, u_y;
  logic               ok_u, ok_v, res_ok;
  logic signed [31:0] out_x_r, out_y_r;
  logic               out_res_r;

  assign qs_x   = d2_neg_x ? -$signed(36'(d2_q_x)) : $signed(36'(d2_q_x));
  assign qs_y   = d2_neg_y ? -$signed(36'(d2_q_y)) : $signed(36'(d2_q_y));
  assign u_x    = qs_x + $signed(36'({tcx, 12'h000}));
  assign u_y    = qs_y + $signed(36'({tcy, 12'h000}));
  assign ok_u   = !d2_ovf_x && ((u_x[35:31] == '0) || (u_x[35:31] == '1));
  assign ok_v   = !d2_ovf_y && ((u_y[35:31] == '0) || (u_y[35:31] == '1));
  assign res_ok = !d2_side.bad && ok_u && ok_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_ok;
      out_x_r   <= res_ok ? u_x[31:0] : '0;
      out_y_r   <= res_ok ? u_y[31:0] : '0;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.target_x  = out_x_r;
  assign out_ch.target_y  = out_y_r;
  assign out_ch.valid_res = out_res_r;

  // ---- checks ------------------------------------------------------------
  // a rejected pixel leaves the block as zeros
  `DPR_ASSERT_NOW(a_reject_zero, out_vld_r && !out_res_r, (out_x_r == '0) && (out_y_r == '0))
  // a point still good after the projection divide sits in front of the camera
  `DPR_ASSERT_NOW(a_zt_positive, d2_vld && !d2_side.bad,
                  (d2_side.word != '0) && !d2_side.word[31])
  // a point still good after back-projection carries a nonzero depth
  `DPR_ASSERT_NEXT(a_depth_nonzero, en && d1_vld && !d1_side.bad, b_z_r != '0)

endmodule

`default_nettype wire

### tb/depth_pixel_reprojection_tb.sv
// ---------------------------------------------------------------------------
// depth_pixel_reprojection_tb
// Streams depth pixels through the reprojection block under several camera
// and transform settings, predicts each projected position, and compares
// every result item in order, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_pixel_reprojection_tb;
  import dpr_pkg::*;

  localparam int  SETTLE_CYCLES = 120;      // beyond the depth of the full pipeline
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ok;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dpr_in_if  pix_if ();
  dpr_out_if proj_if ();

  depth_pixel_reprojection u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (pix_if),
    .out_ch   (proj_if)
  );

  always #2 clk = ~clk;

  // Shadow copy of the camera and transform registers.
  logic [63:0] cam_regs [7];
  proj_t       proj_q [$];
  int          mismatches;
  int          cycle_count;
  int          burst_left;
  bit          gaps_on;
  int          hold_left;

  // -------------------------------------------------------------------------
  // Projection predictor
  // -------------------------------------------------------------------------
  function automatic bit fits_word(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic longint rot_entry(int slot);
    logic [63:0] w;
    w = (slot < 4) ? cam_regs[REG_ROT_FIRST] :
        (slot < 8) ? cam_regs[REG_ROT_SECND] : cam_regs[REG_ROT_LAST];
    return longint'($signed(w[16*(slot%4) +: 16]));
  endfunction

  // r (Q2.14) times p (Q16.16), truncated toward zero
  function automatic longint rot_mul(int slot, longint p);
    return (rot_entry(slot) * p) / 64'sd16384;
  endfunction

  function automatic proj_t project_pixel(logic [11:0] col_in, logic [11:0] row_in,
                                          logic [31:0] depth_in);
    proj_t  r;
    longint col, row, dep;
    longint sfx, sfy, scx, scy, tfx, tfy, tcx, tcy, tx, ty, tz;
    longint x, y, z, xt, yt, zt, u, v;
    r   = '0;
    col = longint'(col_in & COORD_MASK);
    row = longint'(row_in & COORD_MASK);
    dep = longint'({32'd0, depth_in});
    sfx = longint'(cam_regs[REG_SRC_INTR][15:0]);
    sfy = longint'(cam_regs[REG_SRC_INTR][31:16]);
    scx = longint'(cam_regs[REG_SRC_INTR][47:32]);
    scy = longint'(cam_regs[REG_SRC_INTR][63:48]);
    tfx = longint'(cam_regs[REG_TGT_INTR][15:0]);
    tfy = longint'(cam_regs[REG_TGT_INTR][31:16]);
    tcx = longint'(cam_regs[REG_TGT_INTR][47:32]);
    tcy = longint'(cam_regs[REG_TGT_INTR][63:48]);
    tx  = longint'($signed(cam_regs[REG_TRANS_XY][31:0]));
    ty  = longint'($signed(cam_regs[REG_TRANS_XY][63:32]));
    tz  = longint'($signed(cam_regs[REG_TRANS_Z][31:0]));
    if (dep == 0 || sfx == 0 || sfy == 0) return r;
    x = (dep * (col * 16 - scx)) / sfx;
    y = (dep * (row * 16 - scy)) / sfy;
    z = dep;
    if (!fits_word(x) || !fits_word(y)) return r;
    xt = rot_mul(0, x) + rot_mul(1, y) + rot_mul(2, z) + tx;
    yt = rot_mul(3, x) + rot_mul(4, y) + rot_mul(5, z) + ty;
    zt = rot_mul(6, x) + rot_mul(7, y) + rot_mul(8, z) + tz;
    if (!fits_word(xt) || !fits_word(yt) || !fits_word(zt) || zt <= 0) return r;
    u = (xt * tfx * 4096) / zt + tcx * 4096;
    v = (yt * tfy * 4096) / zt + tcy * 4096;
    if (!fits_word(u) || !fits_word(v)) return r;
    r.x  = u[31:0];
    r.y  = v[31:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Register writes and pixel sender
  // -------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    // Mirror the write; narrow registers keep only their low bits.
    if (idx == REG_ROT_LAST)     cam_regs[idx] = {48'd0, data[15:0]};
    else if (idx == REG_TRANS_Z) cam_regs[idx] = {32'd0, data[31:0]};
    else if (idx != REG_UNUSED)  cam_regs[idx] = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] s, logic [63:0] t, logic [63:0] r1,
                           logic [63:0] r2, logic [15:0] r3, logic [63:0] txy,
                           logic [31:0] tz);
    write_reg(REG_SRC_INTR, s);
    write_reg(REG_TGT_INTR, t);
    write_reg(REG_ROT_FIRST, r1);
    write_reg(REG_ROT_SECND, r2);
    write_reg(REG_ROT_LAST, {48'd0, r3});
    write_reg(REG_TRANS_XY, txy);
    write_reg(REG_TRANS_Z, {32'd0, tz});
  endtask

  // Offer one item, hold it until accepted, and queue its projection.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] dep);
    if (gaps_on && burst_left == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    pix_if.valid  <= 1'b1;
    pix_if.column <= col;
    pix_if.row    <= row;
    pix_if.depth  <= dep;
    do @(posedge clk); while (!pix_if.ready);
    proj_q.push_back(project_pixel(col, row, dep));
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and let the pipeline drain before touching registers.
  task automatic drain;
    pix_if.valid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_depth;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'd0;
      2:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_1000, 32'h0014_0000);
    endcase
  endfunction

  function automatic logic [15:0] rand_rot(bit diag);
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return diag ? 16'($urandom_range(12000, 20000))
                : 16'($signed($urandom_range(0, 8000)) - 4000);
  endfunction

  function automatic logic [63:0] rand_intr;
    return {16'($urandom()), 16'($urandom()),
            16'($urandom_range(16, 16000)), 16'($urandom_range(16, 16000))};
  endfunction

  // Plausible camera pair with a near-identity rotation and a small offset.
  task automatic load_random_setup;
    logic [31:0] txw, tyw, tzw;
    txw = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    tyw = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    tzw = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    write_all(rand_intr(), rand_intr(),
              {rand_rot(0), rand_rot(0), rand_rot(0), rand_rot(1)},
              {rand_rot(0), rand_rot(0), rand_rot(0), rand_rot(1)},
              rand_rot(1), {tyw, txw}, tzw);
  endtask

  task automatic send_random(int count);
    repeat (count)
      send_pixel(12'($urandom()), 12'($urandom()), rand_depth());
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_reset_defaults;
    // Identity cameras and transform: depth 0, smallest depth, field extremes.
    send_pixel(12'd0, 12'd0, 32'd0);
    send_pixel(12'd0, 12'd0, 32'd1);
    send_pixel(12'hFFF, 12'hFFF, 32'h0001_0000);
    send_pixel(12'hFFF, 12'd0, 32'hFFFF_FFFF);          // back-projected overflow
    send_pixel(12'd5, 12'd7, 32'h0000_8000);
    drain();
  endtask

  task automatic test_special_cases;
    // Zero source focal length, first fy and then fx.
    write_reg(REG_SRC_INTR, 64'h0000_0000_0000_0010);
    send_pixel(12'd10, 12'd10, 32'h0001_0000);
    drain();
    write_reg(REG_SRC_INTR, 64'h0000_0000_0010_0000);
    send_pixel(12'd10, 12'd10, 32'h0001_0000);
    drain();
    // Write the unused index, which the block must drop, then load new source intrinsics.
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SRC_INTR, 64'h0800_0800_0100_0100);
    send_pixel(12'd3, 12'd200, 32'h0002_0000);
    drain();
    // Behind camera: negative r22.
    write_reg(REG_ROT_LAST, 64'h0000_0000_0000_C000);
    send_pixel(12'd100, 12'd50, 32'h0003_0000);
    drain();
    // Transformed overflow: large tz on a deep pixel.
    write_reg(REG_ROT_LAST, 64'h0000_0000_0000_4000);
    write_reg(REG_TRANS_Z, 64'h0000_0000_7FFF_FFFF);
    send_pixel(12'd128, 12'd128, 32'h4000_0000);
    send_pixel(12'd128, 12'd128, 32'h0000_0001);
    drain();
    // Projected overflow: long target focal length, shallow point.
    write_reg(REG_TRANS_Z, 64'h0000_0000_0000_0000);
    write_reg(REG_TGT_INTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'hFFF, 12'd0, 32'h0000_0100);
    send_pixel(12'd128, 12'd128, 32'h0001_0000);
    drain();
  endtask

  task automatic test_extreme_setups;
    // All registers at their maximum bit patterns.
    write_all('1, '1, '1, '1, '1, '1, '1);
    send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_random(60);
    drain();
    // All registers zero: every pixel hits the zero focal length.
    write_all('0, '0, '0, '0, '0, '0, '0);
    send_random(40);
    drain();
  endtask

  task automatic test_random_setups;
    repeat (6) begin
      load_random_setup();
      send_random(250);
      drain();
    end
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall input.
  task automatic test_output_stall;
    load_random_setup();
    gaps_on   = 1'b0;
    hold_left = 400;
    send_random(200);
    gaps_on = 1'b1;
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Receiver and result check
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      proj_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (cycle_count[10:9])
        2'd0:    proj_if.ready <= 1'b1;
        2'd1:    proj_if.ready <= ($urandom_range(0, 1) == 1);
        2'd2:    proj_if.ready <= ($urandom_range(0, 9) != 0);
        default: proj_if.ready <= cycle_count[2];
      endcase
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    proj_t want;
    if (rst_n && proj_if.valid && proj_if.ready) begin
      if (proj_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = proj_q.pop_front();
        if (proj_if.valid_res !== want.ok)
          report_mismatch("valid_res", proj_if.valid_res, want.ok);
        if (proj_if.target_x !== want.x)
          report_mismatch("target_x", proj_if.target_x, want.x);
        if (proj_if.target_y !== want.y)
          report_mismatch("target_y", proj_if.target_y, want.y);
      end
    end
  end

  // Hard stop on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cycle_count   = 0;
    mismatches    = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_left     = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pix_if.valid  = 1'b0;
    pix_if.column = '0;
    pix_if.row    = '0;
    pix_if.depth  = '0;
    proj_if.ready = 1'b0;
    cam_regs[REG_SRC_INTR]  = 64'h0000_0000_0010_0010;
    cam_regs[REG_TGT_INTR]  = 64'h0000_0000_0010_0010;
    cam_regs[REG_ROT_FIRST] = 64'd16384;
    cam_regs[REG_ROT_SECND] = 64'd16384;
    cam_regs[REG_ROT_LAST]  = 64'd16384;
    cam_regs[REG_TRANS_XY]  = 64'd0;
    cam_regs[REG_TRANS_Z]   = 64'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_extreme_setups();
    test_random_setups();
    test_output_stall();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
